/* rtl/plme_pkg.sv */
// ============================================================================
// plme_pkg - shared types and constants for the piecewise linear mean unit
// Sequencer states, divider handshake structs and the saturating sum helper.
// ============================================================================
package plme_pkg;

    localparam int SUM_WIDTH = 64;
    localparam int MAG_WIDTH = SUM_WIDTH - 1;

    localparam logic [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
    localparam logic [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

    // main sequencer
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_T1,
        S_MUL_T2,
        S_P_ADD,
        S_MUL_M,
        S_M_FIN,
        S_SUM_A,
        S_SUM_M,
        S_EVAL,
        S_DIV,
        S_OUT
    } t_state;

    // divider sequencer
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } t_div_state;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // add two sums held in +-(2^63-1), clamp the result to the same range
    function automatic logic [SUM_WIDTH-1:0] sat_add(
        input logic [SUM_WIDTH-1:0] a,
        input logic [SUM_WIDTH-1:0] b
    );
        logic signed [SUM_WIDTH:0] s;
        logic signed [SUM_WIDTH:0] lim;
        lim = $signed({1'b0, SUM_MAX});
        s   = $signed({a[SUM_WIDTH-1], a}) + $signed({b[SUM_WIDTH-1], b});
        if (s > lim) begin
            return SUM_MAX;
        end else if (s < -lim) begin
            return SUM_MIN + {{(SUM_WIDTH-1){1'b0}}, 1'b1};
        end else begin
            return s[SUM_WIDTH-1:0];
        end
    endfunction

endpackage

/* rtl/plme_div.sv */
// ============================================================================
// plme_div - restoring divider for the mean energy quotient
// Divides (|moment| << frac) by 3*|area|, one quotient bit per cycle,
// and clamps the quotient to the energy width.
// ============================================================================
module plme_div
    import plme_pkg::*;
#(
    parameter int ENERGY_WIDTH     = 24,
    parameter int ENERGY_FRAC_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_div_ctl                i_ctl,
    input  logic [MAG_WIDTH-1:0]    i_num_mag,
    input  logic [MAG_WIDTH-1:0]    i_den_mag,
    output t_div_stat               o_stat,
    output logic [ENERGY_WIDTH-1:0] o_quot
);

    localparam int EW   = ENERGY_WIDTH;
    localparam int NUMW = MAG_WIDTH + ENERGY_FRAC_BITS;
    localparam int DENW = MAG_WIDTH + 2;
    localparam int KW   = $clog2(NUMW);

    t_div_state      r_state, n_state;
    logic [NUMW-1:0] r_num;
    logic [DENW-1:0] r_den;
    logic [DENW-1:0] r_rem;
    logic [EW-1:0]   r_q;
    logic            r_ovf;
    logic [KW-1:0]   r_cnt;

    logic [DENW:0]   rem_sh;
    logic [DENW:0]   rem_sub;
    logic            take;

    assign rem_sh  = {r_rem, r_num[NUMW-1]};
    assign take    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (i_ctl.start) begin
                n_state = DIV_RUN;
            end
            DIV_RUN: if (r_cnt == KW'(NUMW - 1)) begin
                n_state = DIV_DONE;
            end
            DIV_DONE: n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == DIV_IDLE && i_ctl.start) begin
            r_num <= {i_num_mag, {ENERGY_FRAC_BITS{1'b0}}};
            r_den <= (DENW'(i_den_mag) << 1) + DENW'(i_den_mag);
            r_rem <= '0;
            r_q   <= '0;
            r_ovf <= 1'b0;
            r_cnt <= '0;
        end else if (r_state == DIV_RUN) begin
            r_num <= r_num << 1;
            r_rem <= take ? rem_sub[DENW-1:0] : rem_sh[DENW-1:0];
            r_ovf <= r_ovf | r_q[EW-1];
            r_q   <= {r_q[EW-2:0], take};
            r_cnt <= r_cnt + KW'(1);
        end
    end

    assign o_stat.busy = (r_state == DIV_RUN);
    assign o_stat.done = (r_state == DIV_DONE);
    assign o_quot      = r_ovf ? {EW{1'b1}} : r_q;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> (r_state == DIV_IDLE))
        else $error("divider started while busy");

    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.start && r_state == DIV_IDLE) |=> (r_state == DIV_RUN && r_rem == '0))
        else $error("divider did not load on start");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> !o_stat.done)
        else $error("divider done held longer than one cycle");

endmodule

/* rtl/piecewise_linear_mean_energy_unit.sv */
// ============================================================================
// piecewise_linear_mean_energy_unit - mean energy of a piecewise linear spectrum
// Accumulates trapezoid area and first moment per segment on one shared
// multiplier and divides moment by three times area on the last point.
// ============================================================================
//
//  channel   dir  fields (lowest bit first)                handshake
//  s_axis    in   tdata: energy, density; tlast: last pt   tvalid/tready
//  m_axis    out  tdata: mean_energy; tuser: zero_area     tvalid/tready
//
//  For a point after the first, the shared multiplier forms the area, the
//  two moment products and NCH partial products of the moment term one
//  after another.
//  A spectrum's last point then runs the bit-serial divide; a zero area or
//  sums of opposite sign skip the divide.
//  Reset is synchronous and active low; it clears the sums and the held point.
//  s_axis_tready is high only while the sequencer idles. The result word sits
//  in an output register, so input words are taken while it waits.
//
module piecewise_linear_mean_energy_unit
    import plme_pkg::*;
#(
    parameter int ENERGY_WIDTH     = 24,
    parameter int DENSITY_WIDTH    = 24,
    parameter int ENERGY_FRAC_BITS = 16
) (
    input  logic                                                  i_clk,
    input  logic                                                  i_rst_n,
    input  logic                                                  s_axis_tvalid,
    output logic                                                  s_axis_tready,
    // energy, density (zero padded to bytes)
    input  logic [((ENERGY_WIDTH+DENSITY_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    // last_point
    input  logic                                                  s_axis_tlast,
    output logic                                                  m_axis_tvalid,
    input  logic                                                  m_axis_tready,
    // mean_energy (zero padded to bytes)
    output logic [((ENERGY_WIDTH+7)/8)*8-1:0]                     m_axis_tdata,
    // zero_area
    output logic                                                  m_axis_tuser
);

    localparam int EW     = ENERGY_WIDTH;
    localparam int DW     = DENSITY_WIDTH;
    localparam int FB     = ENERGY_FRAC_BITS;
    localparam int M_TDW  = ((EW + 7) / 8) * 8;
    // shared multiplier operand width: covers y0+y1, x1+2*x0 and a chunk
    localparam int MW     = ((EW > DW) ? EW : DW) + 2;
    localparam int PRW    = 2 * MW;
    // y1*(x1+2x0) + y0*(x0+2x1) needs DW+EW+3 bits, cut into NCH chunks
    localparam int PW_RAW = DW + EW + 3;
    localparam int NCH    = (PW_RAW + MW - 1) / MW;
    localparam int PW     = NCH * MW;
    localparam int MAW    = PW + MW;
    localparam int CW     = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AXW    = (PRW > SUM_WIDTH) ? PRW : SUM_WIDTH;
    localparam int MXW    = (MAW > SUM_WIDTH) ? MAW : SUM_WIDTH;

    // ------------------------------------------------------------------
    // state and registers
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic                 r_have_prev;
    logic [SUM_WIDTH-1:0] r_area_sum;
    logic [SUM_WIDTH-1:0] r_moment_sum;
    logic                 r_out_valid;

    logic [EW-1:0]        r_x0, r_x1, r_dx;
    logic [DW-1:0]        r_y0, r_y1;
    logic                 r_neg;
    logic                 r_last;
    logic [PRW-1:0]       r_prod;
    logic [PRW-1:0]       r_area_mag;
    logic [PW-1:0]        r_p;
    logic [MAW-1:0]       r_macc;
    logic [CW-1:0]        r_cnt;
    logic [SUM_WIDTH-1:0] r_aterm;
    logic [SUM_WIDTH-1:0] r_mterm;
    logic [EW-1:0]        r_res_mean;
    logic                 r_res_zero;
    logic [EW-1:0]        r_out_mean;
    logic                 r_out_zero;

    // ------------------------------------------------------------------
    // input decode and handshakes
    // ------------------------------------------------------------------
    logic [EW-1:0] in_x;
    logic [DW-1:0] in_y;
    logic          in_acc;
    logic          out_free;
    logic          out_load;

    assign in_x          = s_axis_tdata[EW-1:0];
    assign in_y          = s_axis_tdata[EW+DW-1:EW];
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign out_load      = (r_state == S_OUT) && out_free;

    // ------------------------------------------------------------------
    // shared multiplier: operands picked by the sequencer state
    // ------------------------------------------------------------------
    logic [MW-1:0]  mul_a, mul_b;
    logic [PRW-1:0] mul_p;

    always_comb begin
        case (r_state)
            S_MUL_A: begin
                mul_a = MW'(r_y0) + MW'(r_y1);
                mul_b = MW'(r_dx);
            end
            S_MUL_T1: begin
                mul_a = MW'(r_y1);
                mul_b = MW'(r_x1) + MW'({r_x0, 1'b0});
            end
            S_MUL_T2: begin
                mul_a = MW'(r_y0);
                mul_b = MW'(r_x0) + MW'({r_x1, 1'b0});
            end
            S_MUL_M: begin
                // top chunk first, Horner style accumulation below
                mul_a = r_p[PW-1 -: MW];
                mul_b = MW'(r_dx);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // ------------------------------------------------------------------
    // segment terms: saturate magnitudes to 2^63-1, then apply the sign
    // ------------------------------------------------------------------
    logic [AXW-1:0]       area_ext;
    logic [SUM_WIDTH-1:0] a_mag, aterm;
    logic [MAW-1:0]       mom_sh;
    logic [MXW-1:0]       mom_ext;
    logic [SUM_WIDTH-1:0] m_mag, mterm;

    assign area_ext = AXW'(r_area_mag);
    assign a_mag    = (area_ext > AXW'(SUM_MAX)) ? SUM_MAX : area_ext[SUM_WIDTH-1:0];
    assign aterm    = r_neg ? (SUM_WIDTH'(0) - a_mag) : a_mag;

    // the shift acts on the magnitude, so the term truncates toward zero
    assign mom_sh   = r_macc >> FB;
    assign mom_ext  = MXW'(mom_sh);
    assign m_mag    = (mom_ext > MXW'(SUM_MAX)) ? SUM_MAX : mom_ext[SUM_WIDTH-1:0];
    assign mterm    = r_neg ? (SUM_WIDTH'(0) - m_mag) : m_mag;

    // ------------------------------------------------------------------
    // end of spectrum checks and divider
    // ------------------------------------------------------------------
    logic                 area_zero;
    logic                 sign_clash;
    logic [SUM_WIDTH-1:0] area_abs, mom_abs;
    t_div_ctl             div_ctl;
    t_div_stat            div_stat;
    logic [EW-1:0]        div_quot;

    assign area_zero  = (r_area_sum == '0);
    assign sign_clash = (r_moment_sum[SUM_WIDTH-1] != r_area_sum[SUM_WIDTH-1]) &&
                        (r_moment_sum != '0);
    assign area_abs   = r_area_sum[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - r_area_sum) : r_area_sum;
    assign mom_abs    = r_moment_sum[SUM_WIDTH-1] ? (SUM_WIDTH'(0) - r_moment_sum)
                                                  : r_moment_sum;

    plme_div #(
        .ENERGY_WIDTH     (EW),
        .ENERGY_FRAC_BITS (FB)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (div_ctl),
        .i_num_mag (mom_abs[MAG_WIDTH-1:0]),
        .i_den_mag (area_abs[MAG_WIDTH-1:0]),
        .o_stat    (div_stat),
        .o_quot    (div_quot)
    );

    // ------------------------------------------------------------------
    // sequencer: next state and divider start
    // ------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        div_ctl.start = 1'b0;
        unique case (r_state)
            S_IDLE: if (in_acc) begin
                if (r_have_prev) begin
                    n_state = S_MUL_A;
                end else if (s_axis_tlast) begin
                    n_state = S_EVAL;
                end
            end
            S_MUL_A:  n_state = S_MUL_T1;
            S_MUL_T1: n_state = S_MUL_T2;
            S_MUL_T2: n_state = S_P_ADD;
            S_P_ADD:  n_state = S_MUL_M;
            S_MUL_M: if (r_cnt == CW'(NCH - 1)) begin
                n_state = S_M_FIN;
            end
            S_M_FIN:  n_state = S_SUM_A;
            S_SUM_A:  n_state = S_SUM_M;
            S_SUM_M:  n_state = r_last ? S_EVAL : S_IDLE;
            S_EVAL: begin
                if (area_zero || sign_clash) begin
                    n_state = S_OUT;
                end else begin
                    div_ctl.start = 1'b1;
                    n_state       = S_DIV;
                end
            end
            S_DIV: if (div_stat.done) begin
                n_state = S_OUT;
            end
            S_OUT: if (out_free) begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // control state: sequencer, sums, held point flag, output valid
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_have_prev  <= 1'b0;
            r_area_sum   <= '0;
            r_moment_sum <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: if (in_acc) begin
                    r_have_prev <= 1'b1;
                end
                S_SUM_A: r_area_sum   <= sat_add(r_area_sum, r_aterm);
                S_SUM_M: r_moment_sum <= sat_add(r_moment_sum, r_mterm);
                S_OUT: if (out_free) begin
                    // drop the spectrum once its result is handed over
                    r_have_prev  <= 1'b0;
                    r_area_sum   <= '0;
                    r_moment_sum <= '0;
                end
                default: ;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: if (in_acc) begin
                r_last <= s_axis_tlast;
                if (r_have_prev) begin
                    r_x1  <= in_x;
                    r_y1  <= in_y;
                    r_neg <= (in_x < r_x0);
                    r_dx  <= (in_x < r_x0) ? (r_x0 - in_x) : (in_x - r_x0);
                end else begin
                    r_x0 <= in_x;
                    r_y0 <= in_y;
                end
            end
            S_MUL_T1: r_area_mag <= r_prod;
            S_MUL_T2: r_p <= PW'(r_prod);
            S_P_ADD: begin
                r_p   <= r_p + PW'(r_prod);
                r_cnt <= '0;
            end
            S_MUL_M: begin
                r_p    <= r_p << MW;
                r_macc <= (r_cnt == '0) ? '0 : ((r_macc << MW) + MAW'(r_prod));
                r_cnt  <= r_cnt + CW'(1);
            end
            S_M_FIN: begin
                r_macc  <= (r_macc << MW) + MAW'(r_prod);
                r_aterm <= aterm;
            end
            S_SUM_A: r_mterm <= mterm;
            S_SUM_M: begin
                // advance the held point
                r_x0 <= r_x1;
                r_y0 <= r_y1;
            end
            S_EVAL: begin
                r_res_zero <= area_zero;
                r_res_mean <= '0;
            end
            S_DIV: if (div_stat.done) begin
                r_res_mean <= div_quot;
            end
            S_OUT: if (out_load) begin
                r_out_mean <= r_res_mean;
                r_out_zero <= r_res_zero;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDW'(r_out_mean);
    assign m_axis_tuser  = r_out_zero;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_seg_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_have_prev) |=> (r_state == S_MUL_A))
        else $error("segment did not start after a held point");

    a_zero_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zero) |-> (r_out_mean == '0))
        else $error("zero area result with non-zero mean");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (!r_have_prev && r_area_sum == '0 && r_moment_sum == '0))
        else $error("state not cleared after a result");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_area_sum != SUM_MIN) && (r_moment_sum != SUM_MIN))
        else $error("running sum left the saturation range");

endmodule
